// ===== rtl/core/pph_pkg.sv =====
package pph_pkg;

  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIST_LAT  = 4 * MUL_LAT + 5;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               apply_distortion;
  } pph_in_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               saturated;
  } pph_out_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_TANGENT_P1,
    REG_TANGENT_P2
  } reg_idx_t;

  localparam logic        [31:0] RST_FOCAL_X  = 32'd96567296;
  localparam logic        [31:0] RST_FOCAL_Y  = 32'd97360282;
  localparam logic        [31:0] RST_CENTER_X = 32'd43209478;
  localparam logic        [31:0] RST_CENTER_Y = 32'd34464461;
  localparam logic signed [31:0] RST_K1       = -32'sd122379137;
  localparam logic signed [31:0] RST_K2       = 32'sd32534433;
  localparam logic signed [31:0] RST_P1       = 32'sd778462;
  localparam logic signed [31:0] RST_P2       = 32'sd139995;

  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } sval_t;

  function automatic sval_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    sval_t r;
    logic signed [63:0] s;
    s = a + b;
    r.sat = (a[63] == b[63]) && (s[63] != a[63]);
    r.val = r.sat ? (a[63] ? S64_MIN : S64_MAX) : s;
    return r;
  endfunction

endpackage

// ===== rtl/core/pph_dly.sv =====
module pph_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) pipe_r[i] <= '0;
    end else if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[D-1];

endmodule

// ===== rtl/core/pph_div.sv =====
module pph_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_a,
  input  logic [31:0] num_b,
  input  logic [30:0] den,
  output logic [63:0] q_a,
  output logic [63:0] q_b
);

  localparam int unsigned N = pph_pkg::DIV_STEPS;

  logic [31:0] na_r [N];
  logic [31:0] nb_r [N];
  logic [30:0] ra_r [N];
  logic [30:0] rb_r [N];
  logic [30:0] dn_r [N];
  logic [63:0] qa_r [N];
  logic [63:0] qb_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [31:0] na_in, nb_in, ta, tb, dz;
    logic [30:0] ra_in, rb_in, dn_in;
    logic [63:0] qa_in, qb_in;
    if (g == 0) begin : g_first
      assign na_in = num_a;
      assign nb_in = num_b;
      assign ra_in = '0;
      assign rb_in = '0;
      assign dn_in = den;
      assign qa_in = '0;
      assign qb_in = '0;
    end else begin : g_next
      assign na_in = na_r[g-1];
      assign nb_in = nb_r[g-1];
      assign ra_in = ra_r[g-1];
      assign rb_in = rb_r[g-1];
      assign dn_in = dn_r[g-1];
      assign qa_in = qa_r[g-1];
      assign qb_in = qb_r[g-1];
    end
    assign ta = {ra_in, na_in[31]};
    assign tb = {rb_in, nb_in[31]};
    assign dz = {1'b0, dn_in};

    always_ff @(posedge clk) begin
      if (en) begin
        na_r[g] <= na_in << 1;
        nb_r[g] <= nb_in << 1;
        dn_r[g] <= dn_in;
        if (ta >= dz) begin
          ra_r[g] <= 31'(ta - dz);
          qa_r[g] <= {qa_in[62:0], 1'b1};
        end else begin
          ra_r[g] <= ta[30:0];
          qa_r[g] <= {qa_in[62:0], 1'b0};
        end
        if (tb >= dz) begin
          rb_r[g] <= 31'(tb - dz);
          qb_r[g] <= {qb_in[62:0], 1'b1};
        end else begin
          rb_r[g] <= tb[30:0];
          qb_r[g] <= {qb_in[62:0], 1'b0};
        end
      end
    end
  end

  assign q_a = qa_r[N-1];
  assign q_b = qb_r[N-1];

endmodule

// ===== rtl/core/pph_mul.sv =====
module pph_mul #(
  parameter int unsigned SH = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               sat
);

  logic [63:0]  ma_r, mb_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r;
  logic [127:0] shd;
  logic [63:0]  lim, mag;
  logic         ovf;
  logic signed [63:0] p_r;
  logic         sat_r;

  assign shd = prod_r >> SH;
  assign lim = neg3_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign ovf = (|shd[127:64]) || (shd[63:0] > lim);
  assign mag = ovf ? lim : shd[63:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= a[63] ? (~a + 64'd1) : a;
      mb_r   <= b[63] ? (~b + 64'd1) : b;
      neg1_r <= a[63] ^ b[63];
      p00_r  <= {32'b0, ma_r[31:0]}  * {32'b0, mb_r[31:0]};
      p01_r  <= {32'b0, ma_r[31:0]}  * {32'b0, mb_r[63:32]};
      p10_r  <= {32'b0, ma_r[63:32]} * {32'b0, mb_r[31:0]};
      p11_r  <= {32'b0, ma_r[63:32]} * {32'b0, mb_r[63:32]};
      neg2_r <= neg1_r;
      prod_r <= {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
                + {p11_r, 64'b0};
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? -$signed(mag) : $signed(mag);
      sat_r  <= ovf;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

// ===== rtl/core/pph_dist.sv =====
module pph_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic signed [31:0] k1,
  input  logic signed [31:0] k2,
  input  logic signed [31:0] p1,
  input  logic signed [31:0] p2,
  output logic signed [63:0] na,
  output logic signed [63:0] nb,
  output logic               sat
);

  localparam int unsigned L = pph_pkg::MUL_LAT;

  logic signed [63:0] k1e, k2e, p1e, p2e;
  assign k1e = 64'(k1);
  assign k2e = 64'(k2);
  assign p1e = 64'(p1);
  assign p2e = 64'(p2);

  // squares and cross term
  logic signed [63:0] xy, x2, y2;
  logic               s_xy, s_x2, s_y2;
  pph_mul #(.SH(32)) u_xy (.clk, .en, .a(a), .b(b), .p(xy), .sat(s_xy));
  pph_mul #(.SH(32)) u_x2 (.clk, .en, .a(a), .b(a), .p(x2), .sat(s_x2));
  pph_mul #(.SH(32)) u_y2 (.clk, .en, .a(b), .b(b), .p(y2), .sat(s_y2));

  pph_pkg::sval_t r2s, x2ds, y2ds;
  logic signed [63:0] r2_r, x2d_r, y2d_r, xy1_r;
  logic               sat1_r;
  assign r2s  = pph_pkg::sat_add(x2, y2);
  assign x2ds = pph_pkg::sat_add(x2, x2);
  assign y2ds = pph_pkg::sat_add(y2, y2);

  pph_pkg::sval_t sxs, sys;
  logic signed [63:0] sx_r, sy_r, r2b_r, xy2_r;
  logic               sat2_r;
  assign sxs = pph_pkg::sat_add(r2_r, x2d_r);
  assign sys = pph_pkg::sat_add(r2_r, y2d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r   <= r2s.val;
      x2d_r  <= x2ds.val;
      y2d_r  <= y2ds.val;
      xy1_r  <= xy;
      sat1_r <= s_xy | s_x2 | s_y2 | r2s.sat | x2ds.sat | y2ds.sat;
      sx_r   <= sxs.val;
      sy_r   <= sys.val;
      r2b_r  <= r2_r;
      xy2_r  <= xy1_r;
      sat2_r <= sat1_r | sxs.sat | sys.sat;
    end
  end

  // second-order terms and r2 squared
  logic signed [63:0] r4, k1r2, p1xy, p2xy, p2sx, p1sy;
  logic               s_r4, s_k1r2, s_p1xy, s_p2xy, s_p2sx, s_p1sy, sat2_d;
  pph_mul #(.SH(32)) u_r4   (.clk, .en, .a(r2b_r), .b(r2b_r), .p(r4),   .sat(s_r4));
  pph_mul #(.SH(28)) u_k1r2 (.clk, .en, .a(k1e),   .b(r2b_r), .p(k1r2), .sat(s_k1r2));
  pph_mul #(.SH(27)) u_p1xy (.clk, .en, .a(p1e),   .b(xy2_r), .p(p1xy), .sat(s_p1xy));
  pph_mul #(.SH(27)) u_p2xy (.clk, .en, .a(p2e),   .b(xy2_r), .p(p2xy), .sat(s_p2xy));
  pph_mul #(.SH(28)) u_p2sx (.clk, .en, .a(p2e),   .b(sx_r),  .p(p2sx), .sat(s_p2sx));
  pph_mul #(.SH(28)) u_p1sy (.clk, .en, .a(p1e),   .b(sy_r),  .p(p1sy), .sat(s_p1sy));
  pph_dly #(.W(1), .D(L)) u_sat2_dly (.clk, .rst_n, .en, .d(sat2_r), .q(sat2_d));

  pph_pkg::sval_t c0as, tas, tbs;
  logic signed [63:0] c0a_r, ta_r, tb_r, r4_r;
  logic               sat3_r;
  assign c0as = pph_pkg::sat_add(pph_pkg::ONE_Q32, k1r2);
  assign tas  = pph_pkg::sat_add(p1xy, p2sx);
  assign tbs  = pph_pkg::sat_add(p2xy, p1sy);

  always_ff @(posedge clk) begin
    if (en) begin
      c0a_r  <= c0as.val;
      ta_r   <= tas.val;
      tb_r   <= tbs.val;
      r4_r   <= r4;
      sat3_r <= sat2_d | s_r4 | s_k1r2 | s_p1xy | s_p2xy | s_p2sx | s_p1sy
                | c0as.sat | tas.sat | tbs.sat;
    end
  end

  // fourth-order radial term
  logic signed [63:0] k2r4, c0a_d;
  logic               s_k2r4;
  logic [128:0]       tt_d;
  pph_mul #(.SH(28)) u_k2r4 (.clk, .en, .a(k2e), .b(r4_r), .p(k2r4), .sat(s_k2r4));
  pph_dly #(.W(64), .D(L)) u_c0a_dly (.clk, .rst_n, .en, .d(c0a_r), .q(c0a_d));
  pph_dly #(.W(129), .D(2 * L + 1)) u_tt_dly (
    .clk, .rst_n, .en, .d({sat3_r, ta_r, tb_r}), .q(tt_d)
  );

  pph_pkg::sval_t c0s;
  logic signed [63:0] c0_r;
  logic               sat4_r, sat4_d;
  assign c0s = pph_pkg::sat_add(c0a_d, k2r4);

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r   <= c0s.val;
      sat4_r <= s_k2r4 | c0s.sat;
    end
  end
  pph_dly #(.W(1), .D(L)) u_sat4_dly (.clk, .rst_n, .en, .d(sat4_r), .q(sat4_d));

  // radial scaling of the normalised point
  logic [127:0]       ab_d;
  logic signed [63:0] ca, cb;
  logic               s_ca, s_cb;
  pph_dly #(.W(128), .D(3 * L + 4)) u_ab_dly (.clk, .rst_n, .en, .d({a, b}), .q(ab_d));
  pph_mul #(.SH(32)) u_ca (.clk, .en, .a(c0_r), .b($signed(ab_d[127:64])), .p(ca), .sat(s_ca));
  pph_mul #(.SH(32)) u_cb (.clk, .en, .a(c0_r), .b($signed(ab_d[63:0])),   .p(cb), .sat(s_cb));

  pph_pkg::sval_t nas, nbs;
  logic signed [63:0] na_r, nb_r;
  logic               sat_r;
  assign nas = pph_pkg::sat_add(ca, $signed(tt_d[127:64]));
  assign nbs = pph_pkg::sat_add(cb, $signed(tt_d[63:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      na_r  <= nas.val;
      nb_r  <= nbs.val;
      sat_r <= tt_d[128] | sat4_d | s_ca | s_cb | nas.sat | nbs.sat;
    end
  end

  assign na  = na_r;
  assign nb  = nb_r;
  assign sat = sat_r;

endmodule

// ===== rtl/core/pinhole_projection_with_distortion.sv =====
// Projects one camera-frame point per cycle to pixel coordinates, with optional
// Brown-Conrady distortion (k1, k2, p1, p2). Each point passes through the
// 64-stage bit-per-stage divider for x/z and y/z, the distortion datapath (four
// rounds of multipliers) and the focal multiply. A new item may enter every
// cycle; out_stall freezes the whole pipeline. Points with negative depth are
// dropped; zero depth or any clipping sets saturated. Write the cfg_ registers
// only while the pipeline is empty.
module pinhole_projection_with_distortion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pph_pkg::pph_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output pph_pkg::pph_out_t out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned L        = pph_pkg::MUL_LAT;
  localparam int unsigned D_SIGN   = pph_pkg::DIV_STEPS;
  localparam int unsigned D_MUX    = pph_pkg::DIV_STEPS + 1 + pph_pkg::DIST_LAT;
  localparam int unsigned D_SIDE   = D_MUX + L;

  logic        en;
  logic        out_valid_r, out_zero_r;
  pph_pkg::pph_out_t out_item_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // configuration
  logic        [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [31:0] k1_r, k2_r, p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= pph_pkg::RST_FOCAL_X;
      focal_y_r  <= pph_pkg::RST_FOCAL_Y;
      center_x_r <= pph_pkg::RST_CENTER_X;
      center_y_r <= pph_pkg::RST_CENTER_Y;
      k1_r       <= pph_pkg::RST_K1;
      k2_r       <= pph_pkg::RST_K2;
      p1_r       <= pph_pkg::RST_P1;
      p2_r       <= pph_pkg::RST_P2;
    end else if (cfg_we) begin
      case (pph_pkg::reg_idx_t'(cfg_index))
        pph_pkg::REG_FOCAL_X:    focal_x_r  <= cfg_data;
        pph_pkg::REG_FOCAL_Y:    focal_y_r  <= cfg_data;
        pph_pkg::REG_CENTER_X:   center_x_r <= cfg_data;
        pph_pkg::REG_CENTER_Y:   center_y_r <= cfg_data;
        pph_pkg::REG_RADIAL_K1:  k1_r       <= cfg_data;
        pph_pkg::REG_RADIAL_K2:  k2_r       <= cfg_data;
        pph_pkg::REG_TANGENT_P1: p1_r       <= cfg_data;
        pph_pkg::REG_TANGENT_P2: p2_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage: magnitudes and flags
  logic        s0_valid_r, s0_zero_r, s0_dist_r, s0_sx_r, s0_sy_r;
  logic [3:0]  s0_zc_r;
  logic [31:0] s0_mx_r, s0_my_r;
  logic [30:0] s0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid && !in_item.point_z[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mx_r   <= in_item.point_x[31] ? (~in_item.point_x + 32'd1) : in_item.point_x;
      s0_my_r   <= in_item.point_y[31] ? (~in_item.point_y + 32'd1) : in_item.point_y;
      s0_sx_r   <= in_item.point_x[31];
      s0_sy_r   <= in_item.point_y[31];
      s0_den_r  <= in_item.point_z[30:0];
      s0_zero_r <= (in_item.point_z == '0);
      s0_dist_r <= in_item.apply_distortion;
      s0_zc_r   <= {!in_item.point_x[31] && (|in_item.point_x), in_item.point_x[31],
                    !in_item.point_y[31] && (|in_item.point_y), in_item.point_y[31]};
    end
  end

  // x/z and y/z in Q32
  logic [63:0] qa, qb;
  logic [1:0]  sgn_d;
  pph_div u_div (
    .clk, .en, .num_a(s0_mx_r), .num_b(s0_my_r), .den(s0_den_r), .q_a(qa), .q_b(qb)
  );
  pph_dly #(.W(2), .D(D_SIGN)) u_sgn_dly (
    .clk, .rst_n, .en, .d({s0_sx_r, s0_sy_r}), .q(sgn_d)
  );

  logic signed [63:0] a_r, b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= sgn_d[1] ? $signed(~qa + 64'd1) : $signed(qa);
      b_r <= sgn_d[0] ? $signed(~qb + 64'd1) : $signed(qb);
    end
  end

  // distortion
  logic signed [63:0] na, nb;
  logic               dsat;
  pph_dist u_dist (
    .clk, .rst_n, .en, .a(a_r), .b(b_r), .k1(k1_r), .k2(k2_r), .p1(p1_r), .p2(p2_r),
    .na(na), .nb(nb), .sat(dsat)
  );

  logic [127:0]       ab_d;
  logic               dist_d, dsat_d;
  logic signed [63:0] cu, cv;
  pph_dly #(.W(128), .D(pph_pkg::DIST_LAT)) u_ab_dly (
    .clk, .rst_n, .en, .d({a_r, b_r}), .q(ab_d)
  );
  pph_dly #(.W(1), .D(D_MUX)) u_dist_dly (.clk, .rst_n, .en, .d(s0_dist_r), .q(dist_d));
  assign cu = dist_d ? na : $signed(ab_d[127:64]);
  assign cv = dist_d ? nb : $signed(ab_d[63:0]);
  pph_dly #(.W(1), .D(L)) u_dsat_dly (.clk, .rst_n, .en, .d(dist_d && dsat), .q(dsat_d));

  // focal scaling
  logic signed [63:0] pu, pv;
  logic               s_pu, s_pv;
  pph_mul #(.SH(32)) u_fu (
    .clk, .en, .a(cu), .b($signed({32'b0, focal_x_r})), .p(pu), .sat(s_pu)
  );
  pph_mul #(.SH(32)) u_fv (
    .clk, .en, .a(cv), .b($signed({32'b0, focal_y_r})), .p(pv), .sat(s_pv)
  );

  logic [5:0] side_d;
  pph_dly #(.W(6), .D(D_SIDE)) u_side_dly (
    .clk, .rst_n, .en, .d({s0_valid_r, s0_zero_r, s0_zc_r}), .q(side_d)
  );

  // principal point, clip to 32 bits
  pph_pkg::sval_t us, vs;
  logic signed [31:0] u_px, v_px, u_z, v_z;
  logic               u_clip, v_clip;
  assign us = pph_pkg::sat_add(pu, $signed({32'b0, center_x_r}));
  assign vs = pph_pkg::sat_add(pv, $signed({32'b0, center_y_r}));

  always_comb begin
    u_clip = 1'b1;
    v_clip = 1'b1;
    if (us.val > 64'(pph_pkg::S32_MAX))      u_px = pph_pkg::S32_MAX;
    else if (us.val < 64'(pph_pkg::S32_MIN)) u_px = pph_pkg::S32_MIN;
    else begin
      u_px   = us.val[31:0];
      u_clip = 1'b0;
    end
    if (vs.val > 64'(pph_pkg::S32_MAX))      v_px = pph_pkg::S32_MAX;
    else if (vs.val < 64'(pph_pkg::S32_MIN)) v_px = pph_pkg::S32_MIN;
    else begin
      v_px   = vs.val[31:0];
      v_clip = 1'b0;
    end
    u_z = side_d[3] ? pph_pkg::S32_MAX : (side_d[2] ? pph_pkg::S32_MIN : '0);
    v_z = side_d[1] ? pph_pkg::S32_MAX : (side_d[0] ? pph_pkg::S32_MIN : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_d[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero_r <= side_d[4];
      if (side_d[4]) begin
        out_item_r.pixel_u   <= u_z;
        out_item_r.pixel_v   <= v_z;
        out_item_r.saturated <= 1'b1;
      end else begin
        out_item_r.pixel_u   <= u_px;
        out_item_r.pixel_v   <= v_px;
        out_item_r.saturated <= dsat_d | s_pu | s_pv | us.sat | vs.sat | u_clip | v_clip;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> out_valid_r && $stable(out_item_r))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_item_r.saturated &&
      (out_item_r.pixel_u == pph_pkg::S32_MAX || out_item_r.pixel_u == pph_pkg::S32_MIN ||
       out_item_r.pixel_u == '0))
    else $error("zero-depth item not saturated");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
